[rtl/core/assert_macros.svh]
// Assertion macros shared by the timer table RTL.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define STT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define STT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/stt_pkg.sv]
// Package for the software timer table: sizes, codes and state type.
// No dependencies.
package stt_pkg;
	localparam int SLOTS     = 16;
	localparam int ID_BITS   = 16;
	localparam int TIME_BITS = 32;
	localparam int REM_BITS  = (TIME_BITS + 9 > 64) ? 64 : TIME_BITS + 9;
	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_START  = 2'd1,
		CMD_STOP   = 2'd2,
		CMD_DETACH = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		EV_OK        = 3'd0,
		EV_TIMEOUT   = 3'd1,
		EV_REMOVED   = 3'd2,
		EV_NOT_FOUND = 3'd3,
		EV_FULL      = 3'd4,
		EV_DUP       = 3'd5,
		EV_DONE      = 3'd6
	} ev_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_UPD_SUB,
		ST_UPD_ADD,
		ST_SRCH_TO,
		ST_SRCH_RM,
		ST_DONE
	} state_t;
endpackage

[rtl/core/stt_chan_if.sv]
// Valid/ready channel interfaces for commands and events of the timer table.
// No dependencies.
interface stt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] timer_id;
	logic [31:0] interval_ms;
	logic        periodic;
	logic [31:0] elapsed_ms;

	modport source (output valid, command, timer_id, interval_ms, periodic, elapsed_ms,
		input ready);
	modport sink (input valid, command, timer_id, interval_ms, periodic, elapsed_ms,
		output ready);
endinterface

interface stt_evt_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [15:0] event_timer_id;
	logic        last;

	modport source (output valid, event_res, event_timer_id, last, input ready);
	modport sink (input valid, event_res, event_timer_id, last, output ready);
endinterface

[rtl/core/stt_alu.sv]
// Shared add/subtract unit for remaining time, clamped at the most negative value.
// Depends on stt_pkg.
module stt_alu (
	input  logic signed [stt_pkg::REM_BITS-1:0] a,
	input  logic [stt_pkg::TIME_BITS-1:0]       b,
	input  logic                                sub,
	output logic signed [stt_pkg::REM_BITS-1:0] y
);
	import stt_pkg::*;

	logic signed [REM_BITS:0] ax;
	logic signed [REM_BITS:0] bx;
	logic signed [REM_BITS:0] s;

	always_comb begin
		ax = {a[REM_BITS-1], a};
		bx = (REM_BITS+1)'(b);
		s  = sub ? (ax - bx) : (ax + bx);
		// only a subtraction can leave the range, and only downward
		if (s[REM_BITS] != s[REM_BITS-1]) begin
			y = {1'b1, {(REM_BITS-1){1'b0}}};
		end else begin
			y = s[REM_BITS-1:0];
		end
	end
endmodule

[rtl/core/software_timer_table.sv]
// Software timer table top level: slot registers, sequencer and event register.
// Start, stop and detach make one scan over the slots; a tick updates each slot
// (a subtract, and an add after a periodic timeout), then makes one scan per
// timeout and per removal plus one closing scan of each kind; event stalls hold
// the scans.
// One item at a time; ready only when idle. Reset empties the table at once.
// Depends on stt_pkg, stt_chan_if, stt_alu and assert_macros.svh.
`include "assert_macros.svh"
module software_timer_table (
	input  logic      clk,
	input  logic      arst_n,
	stt_req_if.sink   req,
	stt_evt_if.source evt
);
	import stt_pkg::*;

	state_t state_q, state_d;

	logic [SLOTS-1:0]          valid_q, pend_q, tflag_q;
	logic [ID_BITS-1:0]        id_q [SLOTS];
	logic [TIME_BITS-1:0]      ival_q [SLOTS];
	logic signed [REM_BITS-1:0] rem_q [SLOTS];
	logic [SLOTS-1:0]          per_q, att_q;

	cmd_t                 cmd_q;
	logic [ID_BITS-1:0]   cid_q;
	logic [TIME_BITS-1:0] cival_q;
	logic                 cper_q;
	logic [TIME_BITS-1:0] el_q;
	logic [SLOT_W-1:0]    idx_q;

	logic              hit_q, hit_pend_q, free_q;
	logic [SLOT_W-1:0] hit_idx_q, free_idx_q;
	logic              best_q, best_att_q;
	logic [SLOT_W-1:0] best_idx_q;
	logic [ID_BITS-1:0] best_id_q;

	logic               ovalid_q, olast_q;
	ev_t                ores_q;
	logic [ID_BITS-1:0] oid_q;

	logic               scan_last, emit_go, adv;
	logic               cur_hit, fin_hit, fin_hpend, fin_free;
	logic [SLOT_W-1:0]  fin_hidx, fin_fidx;
	logic               cand, fin_found, fin_att;
	logic [SLOT_W-1:0]  fin_idx;
	logic [ID_BITS-1:0] fin_id;
	logic               cur_flag, timeout;
	logic               emit_req, emit_last;
	ev_t                emit_res;
	logic [ID_BITS-1:0] emit_id;
	logic signed [REM_BITS-1:0] alu_y;

	stt_alu u_alu (
		.a   (rem_q[idx_q]),
		.b   ((state_q == ST_UPD_ADD) ? ival_q[idx_q] : el_q),
		.sub (state_q != ST_UPD_ADD),
		.y   (alu_y)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign evt.valid = ovalid_q;
	assign evt.event_res = ores_q;
	assign evt.event_timer_id = 16'(oid_q);
	assign evt.last = olast_q;

	assign scan_last = (idx_q == SLOT_W'(SLOTS - 1));
	assign emit_go   = !ovalid_q || evt.ready;
	assign adv       = !(emit_req && !emit_go);
	assign timeout   = valid_q[idx_q] && !pend_q[idx_q] && alu_y[REM_BITS-1];

	// fold the slot under the cursor into the running scan results
	always_comb begin
		cur_hit   = valid_q[idx_q] && (id_q[idx_q] == cid_q);
		fin_hit   = hit_q || cur_hit;
		fin_hidx  = hit_q ? hit_idx_q : idx_q;
		fin_hpend = hit_q ? hit_pend_q : pend_q[idx_q];
		fin_free  = free_q || !valid_q[idx_q];
		fin_fidx  = free_q ? free_idx_q : idx_q;
		cur_flag  = valid_q[idx_q] &&
			((state_q == ST_SRCH_TO) ? tflag_q[idx_q] : pend_q[idx_q]);
		cand      = cur_flag && (!best_q || (id_q[idx_q] < best_id_q));
		fin_found = best_q || cand;
		fin_idx   = cand ? idx_q : best_idx_q;
		fin_id    = cand ? id_q[idx_q] : best_id_q;
		fin_att   = cand ? att_q[idx_q] : best_att_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = (cmd_t'(req.command) == CMD_TICK) ? ST_UPD_SUB : ST_FIND;
				end
			end
			ST_FIND: begin
				if (scan_last && emit_go) state_d = ST_IDLE;
			end
			ST_UPD_SUB: begin
				if (timeout && per_q[idx_q]) state_d = ST_UPD_ADD;
				else if (scan_last) state_d = ST_SRCH_TO;
			end
			ST_UPD_ADD: begin
				state_d = scan_last ? ST_SRCH_TO : ST_UPD_SUB;
			end
			ST_SRCH_TO: begin
				if (scan_last && !fin_found) state_d = ST_SRCH_RM;
			end
			ST_SRCH_RM: begin
				if (scan_last && !fin_found) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (emit_go) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit_req  = 1'b0;
		emit_res  = EV_OK;
		emit_id   = cid_q;
		emit_last = 1'b1;
		unique case (state_q)
			ST_FIND: begin
				emit_req = scan_last;
				if (cmd_q == CMD_START) begin
					if (fin_hit) emit_res = EV_DUP;
					else if (!fin_free) emit_res = EV_FULL;
				end else if (!fin_hit || (cmd_q == CMD_STOP && fin_hpend)) begin
					emit_res = EV_NOT_FOUND;
				end
			end
			ST_SRCH_TO: begin
				emit_req  = scan_last && fin_found;
				emit_res  = EV_TIMEOUT;
				emit_id   = fin_id;
				emit_last = 1'b0;
			end
			ST_SRCH_RM: begin
				emit_req  = scan_last && fin_found && fin_att;
				emit_res  = EV_REMOVED;
				emit_id   = fin_id;
				emit_last = 1'b0;
			end
			ST_DONE: begin
				emit_req = 1'b1;
				emit_res = EV_DONE;
				emit_id  = '0;
			end
			default: emit_req = 1'b0;
		endcase
	end

	// control state and per-slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_q  <= '0;
			pend_q   <= '0;
			tflag_q  <= '0;
			ovalid_q <= 1'b0;
			idx_q    <= '0;
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
			best_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			ovalid_q <= (emit_req && emit_go) || (ovalid_q && !evt.ready);
			unique case (state_q)
				ST_IDLE: idx_q <= '0;
				ST_FIND: begin
					if (adv) begin
						idx_q  <= scan_last ? '0 : idx_q + 1'b1;
						hit_q  <= scan_last ? 1'b0 : fin_hit;
						free_q <= scan_last ? 1'b0 : fin_free;
						if (scan_last) begin
							if (cmd_q == CMD_START) begin
								if (!fin_hit && fin_free) begin
									valid_q[fin_fidx] <= 1'b1;
									pend_q[fin_fidx]  <= 1'b0;
								end
							end else if (emit_res == EV_OK) begin
								pend_q[fin_hidx] <= 1'b1;
							end
						end
					end
				end
				ST_UPD_SUB: begin
					if (timeout) begin
						tflag_q[idx_q] <= 1'b1;
						if (!per_q[idx_q]) pend_q[idx_q] <= 1'b1;
					end
					if (!(timeout && per_q[idx_q])) begin
						idx_q <= scan_last ? '0 : idx_q + 1'b1;
					end
				end
				ST_UPD_ADD: idx_q <= scan_last ? '0 : idx_q + 1'b1;
				ST_SRCH_TO, ST_SRCH_RM: begin
					if (adv) begin
						idx_q  <= scan_last ? '0 : idx_q + 1'b1;
						best_q <= scan_last ? 1'b0 : fin_found;
						if (scan_last && fin_found) begin
							if (state_q == ST_SRCH_TO) begin
								tflag_q[fin_idx] <= 1'b0;
							end else begin
								valid_q[fin_idx] <= 1'b0;
								pend_q[fin_idx]  <= 1'b0;
							end
						end
					end
				end
				default: idx_q <= '0;
			endcase
		end
	end

	// payload: command capture, slot contents, scan results, event register
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q   <= cmd_t'(req.command);
			cid_q   <= ID_BITS'(req.timer_id);
			cival_q <= TIME_BITS'(req.interval_ms);
			cper_q  <= req.periodic;
			el_q    <= TIME_BITS'(req.elapsed_ms);
		end
		if (emit_req && emit_go) begin
			ores_q  <= emit_res;
			oid_q   <= emit_id;
			olast_q <= emit_last;
		end
		if (state_q == ST_FIND && adv) begin
			hit_idx_q  <= fin_hidx;
			hit_pend_q <= fin_hpend;
			free_idx_q <= fin_fidx;
			if (scan_last) begin
				if (cmd_q == CMD_START) begin
					if (!fin_hit && fin_free) begin
						id_q[fin_fidx]   <= cid_q;
						ival_q[fin_fidx] <= cival_q;
						rem_q[fin_fidx]  <= REM_BITS'(cival_q);
						per_q[fin_fidx]  <= cper_q;
						att_q[fin_fidx]  <= 1'b1;
					end
				end else if (cmd_q == CMD_DETACH && fin_hit) begin
					att_q[fin_hidx] <= 1'b0;
				end
			end
		end
		if ((state_q == ST_UPD_SUB && valid_q[idx_q]) || state_q == ST_UPD_ADD) begin
			rem_q[idx_q] <= alu_y;
		end
		if ((state_q == ST_SRCH_TO || state_q == ST_SRCH_RM) && adv) begin
			best_idx_q <= fin_idx;
			best_id_q  <= fin_id;
			best_att_q <= fin_att;
		end
	end

	`STT_ASSERT(a_tflag_idle, (state_q == ST_IDLE) |-> (tflag_q == '0), "timeout flags left after tick")
	`STT_ASSERT_ALWAYS(a_pend_valid, (pend_q & ~valid_q) == '0, "removal mark on a free slot")
	`STT_ASSERT(a_done_last, (state_q == ST_DONE && emit_go) |=> (ovalid_q && olast_q), "tick done without last")
endmodule

[tb/sv/tb.sv]
// Testbench for software_timer_table: directed table, then random commands.
// Depends on stt_pkg, stt_chan_if and the block's RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import stt_pkg::*;

	typedef struct packed {
		logic [2:0]  res;
		logic [15:0] id;
		logic        last;
	} event_t;

	typedef struct {
		cmd_t        command;
		logic [15:0] timer_id;
		logic [31:0] interval_ms;
		logic        periodic;
		logic [31:0] elapsed_ms;
		logic        has_expect;
		ev_t         want_res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic quiet = 1'b0;
	int   errors = 0;
	int   n_sent = 0;
	int   n_events = 0;
	int   n_timeouts = 0;
	event_t expected_events[$];

	stt_req_if req();
	stt_evt_if evt();

	software_timer_table u_dut (.clk(clk), .arst_n(arst_n), .req(req), .evt(evt));

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#50ms;
		$display("timeout at %0t", $realtime);
		$display("tb NOT OK");
		$finish;
	end

	// predictor state
	logic                       tbl_valid [SLOTS];
	logic [15:0]                tbl_id [SLOTS];
	logic [31:0]                tbl_interval [SLOTS];
	logic signed [REM_BITS-1:0] tbl_remaining [SLOTS];
	logic                       tbl_periodic [SLOTS];
	logic                       tbl_pending [SLOTS];
	logic                       tbl_attached [SLOTS];

	function automatic int lookup_timer(logic [15:0] id);
		for (int i = 0; i < SLOTS; i++)
			if (tbl_valid[i] && tbl_id[i] == id) return i;
		return -1;
	endfunction

	function automatic void push_event(ev_t r, logic [15:0] id, logic last);
		event_t e;
		e.res = r;
		e.id = id;
		e.last = last;
		expected_events.push_back(e);
		if (r == EV_TIMEOUT) n_timeouts++;
	endfunction

	function automatic void predict_timers(cmd_t c, logic [15:0] id, logic [31:0] ivl,
			logic per, logic [31:0] el);
		int s, n, j, tmp;
		int ord [SLOTS];
		logic signed [REM_BITS:0] wide;
		logic signed [REM_BITS:0] floor_v;
		n = 0;
		floor_v = {2'b11, {(REM_BITS - 1){1'b0}}};
		if (c == CMD_START) begin
			if (lookup_timer(id) >= 0) begin
				push_event(EV_DUP, id, 1'b1);
				return;
			end
			for (s = 0; s < SLOTS; s++) if (!tbl_valid[s]) break;
			if (s >= SLOTS) begin
				push_event(EV_FULL, id, 1'b1);
				return;
			end
			tbl_valid[s] = 1'b1;
			tbl_id[s] = id;
			tbl_interval[s] = ivl;
			tbl_remaining[s] = $signed({{(REM_BITS - 32){1'b0}}, ivl});
			tbl_periodic[s] = per;
			tbl_pending[s] = 1'b0;
			tbl_attached[s] = 1'b1;
			push_event(EV_OK, id, 1'b1);
			return;
		end
		if (c == CMD_STOP || c == CMD_DETACH) begin
			s = lookup_timer(id);
			if (s < 0 || (c == CMD_STOP && tbl_pending[s])) begin
				push_event(EV_NOT_FOUND, id, 1'b1);
				return;
			end
			tbl_pending[s] = 1'b1;
			if (c == CMD_DETACH) tbl_attached[s] = 1'b0;
			push_event(EV_OK, id, 1'b1);
			return;
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (!tbl_valid[i]) continue;
			j = n;
			while (j > 0 && tbl_id[ord[j - 1]] > tbl_id[i]) begin
				ord[j] = ord[j - 1];
				j--;
			end
			ord[j] = i;
			n++;
		end
		for (j = 0; j < n; j++) begin
			tmp = ord[j];
			// saturate at the most negative remaining time
			wide = $signed({tbl_remaining[tmp][REM_BITS-1], tbl_remaining[tmp]})
				- $signed({{(REM_BITS - 31){1'b0}}, el});
			tbl_remaining[tmp] = (wide < floor_v) ? floor_v[REM_BITS-1:0]
				: wide[REM_BITS-1:0];
			if (!tbl_pending[tmp] && tbl_remaining[tmp] < 0) begin
				push_event(EV_TIMEOUT, tbl_id[tmp], 1'b0);
				if (!tbl_periodic[tmp]) tbl_pending[tmp] = 1'b1;
				else tbl_remaining[tmp] = tbl_remaining[tmp]
					+ $signed({{(REM_BITS - 32){1'b0}}, tbl_interval[tmp]});
			end
		end
		for (j = 0; j < n; j++) begin
			tmp = ord[j];
			if (!tbl_pending[tmp]) continue;
			if (tbl_attached[tmp]) push_event(EV_REMOVED, tbl_id[tmp], 1'b0);
			tbl_valid[tmp] = 1'b0;
			tbl_pending[tmp] = 1'b0;
		end
		push_event(EV_DONE, 16'd0, 1'b1);
	endfunction

	task automatic send_command(cmd_t c, logic [15:0] id, logic [31:0] ivl, logic per,
			logic [31:0] el, logic chk, ev_t want);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.command <= c;
		req.timer_id <= id;
		req.interval_ms <= ivl;
		req.periodic <= per;
		req.elapsed_ms <= el;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		if (chk && c != CMD_TICK) begin
			// typed-in answer must agree with the predictor
			if (lookup_timer(id) < 0 && c != CMD_START && want != EV_NOT_FOUND) begin
				$display("%0t table row expected %0d for id %0h, predictor disagrees",
					$realtime, want, id);
				errors++;
			end
		end
		predict_timers(c, id, ivl, per, el);
		if (chk && c != CMD_TICK && expected_events[$].res != want) begin
			$display("%0t row expected %0d actual predicted %0d", $realtime, want,
				expected_events[$].res);
			errors++;
		end
		n_sent++;
		@(negedge clk);
	endtask

	// event side: random backpressure, checked at the rising edge
	initial begin
		evt.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				evt.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end
			evt.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && evt.valid && evt.ready) begin
			event_t e;
			n_events++;
			if (expected_events.size() == 0) begin
				$display("%0t unexpected event res=%0d id=%0h", $realtime,
					evt.event_res, evt.event_timer_id);
				errors++;
			end else begin
				e = expected_events.pop_front();
				if (evt.event_res !== e.res)
					$display("%0t event_res expected %0d actual %0d", $realtime,
						e.res, evt.event_res);
				if (evt.event_timer_id !== e.id)
					$display("%0t event_timer_id expected %0h actual %0h", $realtime,
						e.id, evt.event_timer_id);
				if (evt.last !== e.last)
					$display("%0t last expected %0b actual %0b", $realtime,
						e.last, evt.last);
				if (evt.event_res !== e.res || evt.event_timer_id !== e.id
						|| evt.last !== e.last)
					errors++;
			end
		end
	end

	function automatic logic [15:0] pick_id();
		// mostly a small pool so starts and stops collide
		case ($urandom_range(0, 9))
			0: return 16'hFFFF;
			1: return 16'(($urandom_range(0, 15)) << 12);
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 23));
		endcase
	endfunction

	function automatic logic [31:0] pick_time();
		case ($urandom_range(0, 9))
			0: return 32'hFFFF_FFFF;
			1: return 32'd0;
			2: return $urandom;
			default: return 32'($urandom_range(0, 200));
		endcase
	endfunction

	stim_row_t rows [$];

	task automatic add_row(cmd_t c, logic [15:0] id, logic [31:0] ivl, logic per,
			logic [31:0] el, logic chk, ev_t want);
		stim_row_t r;
		r.command = c;
		r.timer_id = id;
		r.interval_ms = ivl;
		r.periodic = per;
		r.elapsed_ms = el;
		r.has_expect = chk;
		r.want_res = want;
		rows.push_back(r);
	endtask

	initial begin
		cmd_t c;
		req.valid = 1'b0;
		req.command = CMD_TICK;
		req.timer_id = '0;
		req.interval_ms = '0;
		req.periodic = 1'b0;
		req.elapsed_ms = '0;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_pending[i] = 1'b0;
		end
		#1 arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		add_row(CMD_STOP, 16'h0005, 0, 0, 0, 1, EV_NOT_FOUND);
		add_row(CMD_DETACH, 16'hFFFF, 0, 0, 0, 1, EV_NOT_FOUND);
		add_row(CMD_TICK, 0, 0, 0, 32'hFFFF_FFFF, 0, EV_DONE);
		add_row(CMD_START, 16'h0000, 32'hFFFF_FFFF, 0, 0, 1, EV_OK);
		add_row(CMD_START, 16'hFFFF, 32'd0, 1, 0, 1, EV_OK);
		add_row(CMD_START, 16'hFFFF, 32'd9, 0, 0, 1, EV_DUP);
		add_row(CMD_START, 16'h0010, 32'd3, 1, 0, 1, EV_OK);
		add_row(CMD_START, 16'h0008, 32'd1, 0, 0, 1, EV_OK);
		add_row(CMD_TICK, 0, 0, 0, 32'd1, 0, EV_DONE);
		add_row(CMD_TICK, 0, 0, 0, 32'd10, 0, EV_DONE);
		add_row(CMD_START, 16'h0020, 32'd50, 0, 0, 1, EV_OK);
		add_row(CMD_STOP, 16'h0020, 0, 0, 0, 1, EV_OK);
		add_row(CMD_STOP, 16'h0020, 0, 0, 0, 1, EV_NOT_FOUND);
		add_row(CMD_DETACH, 16'h0020, 0, 0, 0, 1, EV_OK);
		add_row(CMD_START, 16'h0020, 32'd5, 0, 0, 1, EV_DUP);
		add_row(CMD_DETACH, 16'h0010, 0, 0, 0, 1, EV_OK);
		add_row(CMD_TICK, 0, 0, 0, 32'hFFFF_FFFF, 0, EV_DONE);
		add_row(CMD_TICK, 0, 0, 0, 32'hFFFF_FFFF, 0, EV_DONE);
		for (int i = 0; i < 17; i++)
			add_row(CMD_START, 16'(16'h0100 + i), 32'd7, 1'(i), 0, 1,
				(i < SLOTS - 1) ? EV_OK : EV_FULL);
		foreach (rows[i])
			send_command(rows[i].command, rows[i].timer_id, rows[i].interval_ms,
				rows[i].periodic, rows[i].elapsed_ms, rows[i].has_expect,
				rows[i].want_res);
		// drain the one-shot timers with huge ticks before the random part; periodic ones stay
		repeat (4) send_command(CMD_TICK, 0, 0, 0, 32'hFFFF_FFFF, 0, EV_DONE);

		for (int n = 0; n < 340; n++) begin
			if (n >= 300) quiet = 1'b1;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: c = CMD_START;
				4: c = CMD_STOP;
				5: c = CMD_DETACH;
				default: c = CMD_TICK;
			endcase
			send_command(c, pick_id(), pick_time(), 1'($urandom), pick_time(), 0, EV_OK);
		end
		req.valid <= 1'b0;

		while (expected_events.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("sent %0d commands, checked %0d events (%0d timeouts)", n_sent,
			n_events, n_timeouts);
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/stt_pkg.sv
rtl/core/stt_chan_if.sv
rtl/core/stt_alu.sv
rtl/core/software_timer_table.sv
tb/sv/tb.sv
